// ===== hdl/dhc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types, constants and the CRC step for the datagram header checker.
// ----------------------------------------------------------------------------
package dhc_pkg;

    localparam int unsigned COUNT_W     = 11;
    localparam int unsigned HDR_BYTES   = 32;
    localparam int unsigned HDR_IDX_W   = $clog2(HDR_BYTES);
    localparam int unsigned CRC_BYTES   = 30;
    localparam int unsigned MAX_LEN     = 1600;
    localparam int unsigned LEN_W       = 17;
    localparam logic [15:0] MAGIC_WORD  = 16'h464d;
    localparam logic [7:0]  VERSION_ID  = 8'd1;
    localparam logic [31:0] CRC_POLY    = 32'hedb88320;
    localparam logic [31:0] CRC_PRESET  = 32'hffffffff;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_BAD_HDR = 3'd2,
        ST_BAD_CRC = 3'd3,
        ST_BAD_LEN = 3'd4
    } t_status;

    typedef logic [HDR_BYTES-1:0][7:0] t_header;

    // classified datagram waiting for the back end
    typedef struct packed {
        t_status status;
        t_header hdr;
    } t_item;

    // reflected CRC-32, one byte, bit steps unrolled
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

// ===== hdl/datagram_header_checker.sv =====
// ----------------------------------------------------------------------------
// datagram_header_checker
// Byte-wide datagram header check: CRC-32 over header bytes 0-29, header and
// length checks, decoded header fields on a good datagram.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless full; byte CRC is unrolled, combinational.
// Path: classifier register, then a four-entry queue, then the result register;
// a result waits in the queue while the result register still holds an unpopped one.
// full rises once queued results plus the one in the classifier register reach four.
// Reset: synchronous, active low; clears count, CRC, queue and result valid.
module datagram_header_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_source_node,
    output logic [15:0] o_destination_node,
    output logic [15:0] o_stream_number,
    output logic [7:0]  o_service_class,
    output logic [7:0]  o_topology_mode,
    output logic [31:0] o_epoch_number,
    output logic [15:0] o_slot_number,
    output logic [31:0] o_sequence_number,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_header_check
);
    import dhc_pkg::*;

    logic  take;
    logic  item_valid;
    t_item item, q_item;
    logic  q_empty, q_rd;

    assign take = push && !full;

    dhc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    dhc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (item_valid),
        .i_wr_item (item),
        .i_rd      (q_rd),
        .o_rd_item (q_item),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    dhc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_q_item           (q_item),
        .o_q_rd             (q_rd),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_status           (o_status),
        .o_source_node      (o_source_node),
        .o_destination_node (o_destination_node),
        .o_stream_number    (o_stream_number),
        .o_service_class    (o_service_class),
        .o_topology_mode    (o_topology_mode),
        .o_epoch_number     (o_epoch_number),
        .o_slot_number      (o_slot_number),
        .o_sequence_number  (o_sequence_number),
        .o_payload_length   (o_payload_length),
        .o_header_check     (o_header_check)
    );

endmodule

// ===== hdl/dhc_front.sv =====
// ----------------------------------------------------------------------------
// dhc_front
// Byte intake: counts bytes, captures the header, runs the header CRC and
// classifies the datagram on its last byte.
// ----------------------------------------------------------------------------
module dhc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output logic           o_item_valid,
    output dhc_pkg::t_item o_item
);
    import dhc_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_crc, n_crc;
    t_header            r_hdr, n_hdr;
    logic               in_range;
    logic [LEN_W-1:0]   want_len;
    t_status            status;

    assign in_range = r_count < COUNT_W'(MAX_LEN);

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (in_range) begin
            n_count = r_count + 1'b1;
            if (r_count < COUNT_W'(CRC_BYTES)) begin
                n_crc = crc_byte(r_crc, i_data_byte);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            n_hdr[i] = r_hdr[i];
            if (r_count < COUNT_W'(HDR_BYTES) && r_count[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) begin
                n_hdr[i] = i_data_byte;
            end
        end
    end

    assign want_len = LEN_W'(HDR_BYTES) + {1'b0, n_hdr[29], n_hdr[28]};

    // first failing check wins
    always_comb begin
        if (n_count < COUNT_W'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if ({n_hdr[1], n_hdr[0]} != MAGIC_WORD || n_hdr[2] != VERSION_ID ||
                     n_hdr[3] != 8'(HDR_BYTES)) begin
            status = ST_BAD_HDR;
        end else if ((n_crc[15:0] ^ CRC_PRESET[15:0]) != {n_hdr[31], n_hdr[30]}) begin
            status = ST_BAD_CRC;
        end else if (LEN_W'(n_count) != want_len) begin
            status = ST_BAD_LEN;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_crc        <= CRC_PRESET;
            o_item_valid <= 1'b0;
        end else begin
            o_item_valid <= i_take && i_last_byte;
            if (i_take) begin
                if (i_last_byte) begin
                    r_count <= '0;
                    r_crc   <= CRC_PRESET;
                end else begin
                    r_count <= n_count;
                    r_crc   <= n_crc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_hdr <= n_hdr;
        end
        if (i_take && i_last_byte) begin
            o_item.status <= status;
            o_item.hdr    <= n_hdr;
        end
    end

endmodule

// ===== hdl/dhc_queue.sv =====
// ----------------------------------------------------------------------------
// dhc_queue
// Short register queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module dhc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dhc_pkg::t_item i_wr_item,
    input  logic           i_rd,
    output dhc_pkg::t_item o_rd_item,
    output logic           o_full,
    output logic           o_empty
);
    import dhc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W:0]   fill_next;
    logic              wr_en, rd_en;

    // a transaction may already sit in the classifier register; keep a slot for it
    assign fill_next = {1'b0, r_cnt} + (QCNT_W+1)'(i_wr);
    assign o_full    = fill_next >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign o_empty   = r_cnt == '0;
    assign wr_en     = i_wr && (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_item = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(wr_en) - QCNT_W'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

endmodule

// ===== hdl/dhc_back.sv =====
// ----------------------------------------------------------------------------
// dhc_back
// Result stage: decodes the little-endian header fields of a classified
// datagram, zeroes them unless the status is ok, and holds the result.
// ----------------------------------------------------------------------------
module dhc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  dhc_pkg::t_item i_q_item,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [2:0]     o_status,
    output logic [15:0]    o_source_node,
    output logic [15:0]    o_destination_node,
    output logic [15:0]    o_stream_number,
    output logic [7:0]     o_service_class,
    output logic [7:0]     o_topology_mode,
    output logic [31:0]    o_epoch_number,
    output logic [15:0]    o_slot_number,
    output logic [31:0]    o_sequence_number,
    output logic [15:0]    o_payload_length,
    output logic [15:0]    o_header_check
);
    import dhc_pkg::*;

    logic    r_valid;
    t_header h;

    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign h       = (i_q_item.status == ST_OK) ? i_q_item.hdr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            o_status           <= i_q_item.status;
            o_source_node      <= {h[9], h[8]};
            o_destination_node <= {h[11], h[10]};
            o_stream_number    <= {h[13], h[12]};
            o_service_class    <= h[14];
            o_topology_mode    <= h[15];
            o_epoch_number     <= {h[21], h[20], h[19], h[18]};
            o_slot_number      <= {h[23], h[22]};
            o_sequence_number  <= {h[27], h[26], h[25], h[24]};
            o_payload_length   <= {h[29], h[28]};
            o_header_check     <= {h[31], h[30]};
        end
    end

endmodule
